/* rtl/assert_macros.svh */
// Assertion macros for the RTL of the daylight saving rule block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that the consequent holds whenever the antecedent does, outside reset.
`define USDST_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// Check that a condition never holds, outside reset.
`define USDST_ASSERT_NEVER(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");

`endif

/* rtl/usdst_pkg.sv */
// Package: word types and constants of the daylight saving rule block
`timescale 1ns / 1ps

package usdst_pkg;

    typedef struct packed {
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
    } query_t;

    typedef struct packed {
        logic        dst_active;
        logic [13:0] next_year;
        logic [3:0]  next_month;
        logic [3:0]  next_day;
    } result_t;

    // Transition Sundays of one year
    typedef struct packed {
        logic [3:0] mar_day;
        logic [3:0] nov_day;
    } sun_days_t;

    // Weekday offsets of the first of each month, January first
    localparam logic [2:0] MonthOffset [12] = '{
        3'd0, 3'd3, 3'd2, 3'd5, 3'd0, 3'd3, 3'd5, 3'd1, 3'd4, 3'd6, 3'd2, 3'd4
    };
    localparam int MarchIndex    = 2;
    localparam int NovemberIndex = 10;

    // floor(q / 25) = (q * Recip25) >> Recip25Shift for q < 4096
    localparam logic [12:0] Recip25      = 13'd5243;
    localparam int          Recip25Shift = 17;

    localparam logic [3:0] MonthMarch    = 4'd3;
    localparam logic [3:0] MonthNovember = 4'd11;
    localparam logic [4:0] SwitchHour    = 5'd2;
    localparam logic [3:0] MaxDay        = 4'd14;

endpackage

/* rtl/usdst_weekday.sv */
// Three-stage pipeline: year to second Sunday of March and first Sunday of November
`timescale 1ns / 1ps

module usdst_weekday (
    input  logic                 clk,
    input  logic [13:0]          year,
    output usdst_pkg::sun_days_t days
);

    // Residue mod 7 of a 15-bit value: octal digits fold since 8 = 1 mod 7
    function automatic logic [2:0] mod7(input logic [14:0] v);
        logic [5:0] s1;
        logic [3:0] s2;
        logic [3:0] r;
        s1 = 6'(v[14:12]) + 6'(v[11:9]) + 6'(v[8:6]) + 6'(v[5:3]) + 6'(v[2:0]);
        s2 = 4'(s1[5:3]) + 4'(s1[2:0]);
        r  = (s2 >= 4'd7) ? (s2 - 4'd7) : s2;
        return r[2:0];
    endfunction

    // First Sunday of the month from the weekday of its first day
    function automatic logic [3:0] opening_sunday(input logic [2:0] w);
        return (w == 3'd0) ? 4'd1 : (4'd8 - 4'(w));
    endfunction

    // Stage 1: quarter year and its reciprocal product for the century terms
    logic [13:0] year_s1_reg;
    logic [11:0] quarter_s1_reg;
    logic [24:0] prod_s1_reg;
    logic [11:0] quarter_next;
    logic [24:0] prod_next;

    assign quarter_next = year[13:2];
    assign prod_next    = 25'(quarter_next) * 25'(usdst_pkg::Recip25);

    always_ff @(posedge clk)
    begin
        year_s1_reg    <= year;
        quarter_s1_reg <= quarter_next;
        prod_s1_reg    <= prod_next;
    end

    // Stage 2: weekday sum plus month offset and day one
    logic [7:0]  cent_next;
    logic [5:0]  quad_next;
    logic [14:0] base_next;
    logic [14:0] sum_mar_next;
    logic [14:0] sum_nov_next;
    logic [14:0] sum_mar_s2_reg;
    logic [14:0] sum_nov_s2_reg;

    assign cent_next    = prod_s1_reg[usdst_pkg::Recip25Shift +: 8];
    assign quad_next    = cent_next[7:2];
    assign base_next    = 15'(year_s1_reg) + 15'(quarter_s1_reg) - 15'(cent_next)
                        + 15'(quad_next);
    assign sum_mar_next = base_next
                        + 15'(usdst_pkg::MonthOffset[usdst_pkg::MarchIndex]) + 15'd1;
    assign sum_nov_next = base_next
                        + 15'(usdst_pkg::MonthOffset[usdst_pkg::NovemberIndex]) + 15'd1;

    always_ff @(posedge clk)
    begin
        sum_mar_s2_reg <= sum_mar_next;
        sum_nov_s2_reg <= sum_nov_next;
    end

    // Stage 3: weekday of the first, then the transition Sundays
    usdst_pkg::sun_days_t days_next;
    usdst_pkg::sun_days_t days_reg;

    assign days_next.mar_day = opening_sunday(mod7(sum_mar_s2_reg)) + 4'd7;
    assign days_next.nov_day = opening_sunday(mod7(sum_nov_s2_reg));

    always_ff @(posedge clk)
    begin
        days_reg <= days_next;
    end

    assign days = days_reg;

endmodule

/* rtl/us_dst_rule_and_next_transition.sv */
// Top level: US daylight saving rule and next transition date, four-stage pipeline
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Usage
//   A query word (year, month, day, hour) is taken at each rising edge with start
//   high and busy low. busy is always low: the pipeline takes one word every
//   cycle, back to back, with no gaps needed.
//   Each query gives exactly one result word on result, marked by done for one
//   cycle. done comes from the valid bit carried through the three weekday
//   stages and the done register; results leave in query order.
//   The pipeline follows the weekday pipeline: three stages (reciprocal multiply
//   for the century terms, weekday sum, mod 7 and Sunday lookup) plus one
//   stage of date compare and select. Throughput is one word per cycle.
//   The receiver cannot stall: each result is valid for its one cycle only, so
//   capture it when done is high.
//   The rule: DST starts at hour 2 on the second Sunday of March and ends at
//   hour 2 on the first Sunday of November. The next transition is this year's
//   March date, else this year's November date, else next year's March date.
//   Reset (rst_n low, asynchronous) clears the valid bits only; queries in
//   flight are dropped and no done is raised for them.
module us_dst_rule_and_next_transition (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  usdst_pkg::query_t   query,
    output logic                done,
    output usdst_pkg::result_t  result
);

    // True when (m, d, h) lies strictly before hour 2 of (tm, td)
    function automatic logic before_switch(
        input logic [3:0] m,
        input logic [4:0] d,
        input logic [4:0] h,
        input logic [3:0] tm,
        input logic [3:0] td
    );
        logic r;
        priority if (m < tm)
            r = 1'b1;
        else if (m > tm)
            r = 1'b0;
        else if (d < 5'(td))
            r = 1'b1;
        else if (d > 5'(td))
            r = 1'b0;
        else
            r = (h < usdst_pkg::SwitchHour);
        return r;
    endfunction

    logic accept;

    // Never back-pressure: a word enters every cycle if offered
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Weekday pipelines for this year and for the following one (14-bit wrap)
    logic [13:0]          year_inc;
    usdst_pkg::sun_days_t days_cur;
    usdst_pkg::sun_days_t days_inc;

    assign year_inc = query.year + 14'd1;

    usdst_weekday u_weekday_cur (
        .clk  (clk),
        .year (query.year),
        .days (days_cur)
    );

    usdst_weekday u_weekday_inc (
        .clk  (clk),
        .year (year_inc),
        .days (days_inc)
    );

    // Carry the query and its valid bit alongside the weekday stages
    logic              valid_s1_reg;
    logic              valid_s2_reg;
    logic              valid_s3_reg;
    logic              done_reg;
    usdst_pkg::query_t query_s1_reg;
    usdst_pkg::query_t query_s2_reg;
    usdst_pkg::query_t query_s3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_s1_reg <= 1'b0;
            valid_s2_reg <= 1'b0;
            valid_s3_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            valid_s1_reg <= accept;
            valid_s2_reg <= valid_s1_reg;
            valid_s3_reg <= valid_s2_reg;
            done_reg     <= valid_s3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        query_s1_reg <= query;
        query_s2_reg <= query_s1_reg;
        query_s3_reg <= query_s2_reg;
    end

    // Stage 4: place the date against both switch points and pick the next one
    logic               before_mar;
    logic               before_nov;
    usdst_pkg::result_t result_next;
    usdst_pkg::result_t result_reg;

    assign before_mar = before_switch(query_s3_reg.month, query_s3_reg.day,
                                      query_s3_reg.hour, usdst_pkg::MonthMarch,
                                      days_cur.mar_day);
    assign before_nov = before_switch(query_s3_reg.month, query_s3_reg.day,
                                      query_s3_reg.hour, usdst_pkg::MonthNovember,
                                      days_cur.nov_day);

    always_comb
    begin
        result_next.dst_active = !before_mar && before_nov;
        priority if (before_mar)
        begin
            result_next.next_year  = query_s3_reg.year;
            result_next.next_month = usdst_pkg::MonthMarch;
            result_next.next_day   = days_cur.mar_day;
        end
        else if (before_nov)
        begin
            result_next.next_year  = query_s3_reg.year;
            result_next.next_month = usdst_pkg::MonthNovember;
            result_next.next_day   = days_cur.nov_day;
        end
        else
        begin
            // Past this year's November switch: roll to next year's March
            result_next.next_year  = query_s3_reg.year + 14'd1;
            result_next.next_month = usdst_pkg::MonthMarch;
            result_next.next_day   = days_inc.mar_day;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

    // Result field checks, kept as signals so each assertion stays short
    logic month_ok;
    logic day_ok;

    assign month_ok = (result.next_month == usdst_pkg::MonthMarch)
                   || (result.next_month == usdst_pkg::MonthNovember);
    assign day_ok   = (result.next_day != 4'd0) && (result.next_day <= usdst_pkg::MaxDay);

    // Every result traces back to an accepted word
    `USDST_ASSERT_IMP(a_done_follows_start, done, $past(start, 4))
    // Every accepted word yields a result
    `USDST_ASSERT_IMP(a_start_gives_done, start, ##4 done)
    // Next transition month is March or November
    `USDST_ASSERT_IMP(a_month_legal, done, month_ok)
    // Transition Sunday lies within the first two weeks
    `USDST_ASSERT_NEVER(a_day_range, done && !day_ok)

endmodule
